// ----- hw/rtl/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and byte functions for the AES-128 cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned ROUNDS_DEF = 10;
    localparam int unsigned KEY_W      = 64;
    localparam int unsigned BLK_W      = 128;

    typedef enum logic [0:0] {
        KIND_ENC = 1'b0,
        KIND_DEC = 1'b1
    } kind_t;

    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEYX,
        ST_RUN,
        ST_DONE
    } core_state_t;

    typedef struct packed {
        logic              kind;
        logic [BLK_W-1:0]  blk;
    } job_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte k of a 128-bit block, byte 0 in the top bits
    function automatic logic [7:0] get_b(input logic [127:0] s, input int k);
        return s[127-8*k -: 8];
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0]   b [16];
        logic [7:0]   o [16];
        logic [7:0]   a0, a1, a2, a3;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int rr = 0; rr < 4; rr++) begin
                b[rr + 4*c] = sbox(get_b(s, rr + 4*((c + rr) % 4)));
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = b[4*c]; a1 = b[4*c+1]; a2 = b[4*c+2]; a3 = b[4*c+3];
            if (last) begin
                o[4*c] = a0; o[4*c+1] = a1; o[4*c+2] = a2; o[4*c+3] = a3;
            end else begin
                o[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                o[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                o[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                o[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
        for (int k = 0; k < 16; k++) r[127-8*k -: 8] = o[k];
        return r;
    endfunction

    // inverse shift rows then inverse sub bytes
    function automatic logic [127:0] dec_sub(input logic [127:0] s);
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int rr = 0; rr < 4; rr++) begin
                r[127-8*(rr+4*c) -: 8] = inv_sbox(get_b(s, rr + 4*((c + 4 - rr) % 4)));
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] r;
        logic [7:0]   a [4];
        logic [7:0]   x2 [4];
        logic [7:0]   x4 [4];
        logic [7:0]   x8 [4];
        logic [7:0]   m9 [4];
        logic [7:0]   mb [4];
        logic [7:0]   md [4];
        logic [7:0]   me [4];
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                a[j]  = get_b(s, 4*c + j);
                x2[j] = xtime(a[j]);
                x4[j] = xtime(x2[j]);
                x8[j] = xtime(x4[j]);
                m9[j] = x8[j] ^ a[j];
                mb[j] = x8[j] ^ x2[j] ^ a[j];
                md[j] = x8[j] ^ x4[j] ^ a[j];
                me[j] = x8[j] ^ x4[j] ^ x2[j];
            end
            for (int rr = 0; rr < 4; rr++) begin
                r[127-8*(4*c+rr) -: 8] = me[rr] ^ mb[(rr+1)%4] ^ md[(rr+2)%4] ^ m9[(rr+3)%4];
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

// ----- hw/rtl/aes_ram.sv -----
// ----------------------------------------------------------------------------
// aes_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module aes_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 11
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/aes_front.sv -----
// ----------------------------------------------------------------------------
// aes_front
// Two-entry job queue between the input channel and the cipher core.
// ----------------------------------------------------------------------------
module aes_front
    import aes_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);
    job_t q_reg [2];
    logic rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = q_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_reg] <= in_job;
        end
        if (!aresetn) begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- hw/rtl/aes_core.sv -----
// ----------------------------------------------------------------------------
// aes_core
// Round-iterative cipher engine with key expansion into a round key RAM.
// ----------------------------------------------------------------------------
module aes_core
    import aes_pkg::*;
#(
    parameter int unsigned ROUNDS = ROUNDS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              key_start,
    input  logic [BLK_W-1:0]  key,
    input  logic              job_valid,
    output logic              job_ready,
    input  job_t              job,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BLK_W-1:0]  m_data
);
    localparam int unsigned NK = ROUNDS + 1;
    localparam int unsigned AW = $clog2(NK);

    core_state_t      state_reg, state_next;
    logic [AW-1:0]    rnd_reg, rnd_next;
    logic [BLK_W-1:0] st_reg, st_next;
    logic [BLK_W-1:0] kx_reg, kx_next;
    logic [7:0]       rc_reg, rc_next;
    logic             kind_reg, kind_next;
    logic             pend_reg, pend_next;
    logic             ov_reg, ov_next;
    logic [BLK_W-1:0] od_reg, od_next;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [BLK_W-1:0] rk;
    logic [31:0]      t, w0, w1, w2, w3;

    aes_ram #(.WIDTH(BLK_W), .DEPTH(NK)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(kx_reg),
        .raddr(raddr), .rdata(rk)
    );

    assign m_valid = ov_reg;
    assign m_data  = od_reg;

    always_comb begin
        t  = sub_word({kx_reg[23:0], kx_reg[31:24]}) ^ {rc_reg, 24'h0};
        w0 = kx_reg[127:96] ^ t;
        w1 = kx_reg[95:64] ^ w0;
        w2 = kx_reg[63:32] ^ w1;
        w3 = kx_reg[31:0] ^ w2;
    end

    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        st_next    = st_reg;
        kx_next    = kx_reg;
        rc_next    = rc_reg;
        kind_next  = kind_reg;
        pend_next  = pend_reg || key_start;
        ov_next    = ov_reg;
        od_next    = od_reg;
        we         = 1'b0;
        waddr      = rnd_reg;
        raddr      = rnd_reg;
        job_ready  = 1'b0;
        if (ov_reg && m_ready) ov_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (pend_reg || key_start) begin
                    state_next = ST_KEYX;
                    pend_next  = 1'b0;
                    kx_next    = key;
                    rc_next    = 8'h01;
                    rnd_next   = '0;
                end else if (job_valid) begin
                    job_ready  = 1'b1;
                    kind_next  = job.kind;
                    st_next    = job.blk;
                    state_next = ST_RUN;
                    // round key 0 (encrypt) or last (decrypt) is read now
                    rnd_next   = (job.kind == KIND_DEC) ? AW'(ROUNDS) : '0;
                    raddr      = rnd_next;
                end
            end
            ST_KEYX: begin
                we      = 1'b1;
                kx_next = {w0, w1, w2, w3};
                rc_next = xtime(rc_reg);
                if (rnd_reg == AW'(ROUNDS)) begin
                    state_next = ST_IDLE;
                end else begin
                    rnd_next = rnd_reg + 1'b1;
                end
            end
            ST_RUN: begin
                // state holds the value before key add of round rnd_reg
                if (kind_reg == KIND_ENC) begin
                    if (rnd_reg == AW'(ROUNDS)) begin
                        state_next = ST_DONE;
                        st_next    = st_reg ^ rk;
                    end else begin
                        st_next  = enc_round(st_reg ^ rk, (rnd_reg == AW'(ROUNDS - 1)));
                        rnd_next = rnd_reg + 1'b1;
                    end
                end else begin
                    if (rnd_reg == '0) begin
                        state_next = ST_DONE;
                        st_next    = st_reg ^ rk;
                    end else if (rnd_reg == AW'(ROUNDS)) begin
                        st_next  = dec_sub(st_reg ^ rk);
                        rnd_next = rnd_reg - 1'b1;
                    end else begin
                        st_next  = dec_sub(inv_mix(st_reg ^ rk));
                        rnd_next = rnd_reg - 1'b1;
                    end
                end
                raddr = rnd_next;
            end
            ST_DONE: begin
                if (!ov_reg || m_ready) begin
                    ov_next    = 1'b1;
                    od_next    = st_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        rnd_reg  <= rnd_next;
        st_reg   <= st_next;
        kx_reg   <= kx_next;
        rc_reg   <= rc_next;
        kind_reg <= kind_next;
        od_reg   <= od_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b1;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

// ----- hw/rtl/aes128_block_cipher.sv -----
// ----------------------------------------------------------------------------
// aes128_block_cipher
// AES-128 encrypt/decrypt of one 128-bit block per transfer, key held in
// two configuration registers and expanded into a round key RAM.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata[63:0] block_high, [127:64] block_low; tuser kind
// m_axis    out  tdata[63:0] result_high, [127:64] result_low
// cfg       in   cfg_we, cfg_addr (0 key_high, 1 key_low), cfg_wdata[63:0]
//
// In the core a block is started, then takes the initial key add and every
// round in turn through the round logic, then loads the output register.
// After reset, and after every key write, the key expansion runs and no
// block is started meanwhile.
// A two-entry queue takes transfers while the core works; a result waiting
// on m_axis_tready holds the core after its last round.
// ----------------------------------------------------------------------------
module aes128_block_cipher
    import aes_pkg::*;
#(
    parameter int unsigned ROUNDS = ROUNDS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [KEY_W-1:0]  cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BLK_W-1:0]  s_axis_tdata,   // block_high, block_low
    input  logic              s_axis_tuser,   // kind
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BLK_W-1:0]  m_axis_tdata    // result_high, result_low
);
    logic [KEY_W-1:0] key_high_reg, key_low_reg;
    logic             key_start_reg;
    logic             q_valid, q_ready;
    job_t             in_job, q_job;
    logic [BLK_W-1:0] res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            key_start_reg <= 1'b0;
        end else begin
            key_start_reg <= cfg_we;
            if (cfg_we && cfg_addr == REG_KEY_HIGH) key_high_reg <= cfg_wdata;
            if (cfg_we && cfg_addr == REG_KEY_LOW)  key_low_reg  <= cfg_wdata;
        end
    end

    // block_high sits in the low half of tdata, block_low in the high half
    assign in_job.kind = s_axis_tuser;
    assign in_job.blk  = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    aes_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_job(in_job),
        .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
    );

    aes_core #(.ROUNDS(ROUNDS)) u_core (
        .aclk(aclk), .aresetn(aresetn),
        .key_start(key_start_reg), .key({key_high_reg, key_low_reg}),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(res)
    );

    assign m_axis_tdata = {res[63:0], res[127:64]};
endmodule
